### sv/mdio_management_master_unit_assert.svh
// Assertion macros used by the MDIO management master core (mdio_mm_core).
`ifndef MDIO_MANAGEMENT_MASTER_UNIT_ASSERT_SVH
`define MDIO_MANAGEMENT_MASTER_UNIT_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define MDIO_MM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define MDIO_MM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mdio_mm_pkg.sv
`default_nettype none
package mdio_mm_pkg;

  localparam int PREAMBLE_BITS_DEF = 32;
  localparam int PORT_COUNT_DEF    = 2;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [15:0] REG_DIRECT_LIMIT = 16'd32;
  localparam logic [15:0] REG_MMD1F_MAX    = 16'h0EFD;
  localparam logic [15:0] REG_MMDDEV_MIN   = 16'h1000;
  localparam logic [15:0] MMD_ADDR_MASK    = 16'h0FFF;
  localparam logic [4:0]  MMD_DEV_1F       = 5'h1F;
  localparam logic [4:0]  REG_MMD_CTRL     = 5'h0D;
  localparam logic [4:0]  REG_MMD_DATA     = 5'h0E;
  localparam logic [15:0] MMD_DATA_MODE    = 16'h4000;

  localparam logic [1:0] FRAME_LAST_MMD = 2'd3;
  localparam logic [4:0] TAIL_LAST      = 5'd31;
  localparam logic [4:0] TAIL_RX_FIRST  = 5'd16;
  localparam logic [4:0] TAIL_READ_TA   = 5'd14;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_BAD_PORT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_MMD1F  = 2'd1,
    KIND_MMDDEV = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        port_select;
    logic [4:0]  phy_addr;
    logic [15:0] reg_addr;
    logic [15:0] write_data;
    logic        mdio_in;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] read_data;
    logic        done_res;
    logic        busy_res;
    logic        port_sel;
    logic        clock_active;
    logic        mdio_drive_enable;
    logic        mdio_out;
  } result_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  frame;
    logic        is_write;
    logic [4:0]  phy;
    logic [15:0] regnum;
    logic [15:0] value;
  } frame_req_t;

endpackage
`default_nettype wire

### sv/mdio_mm_frame.sv
`default_nettype none
module mdio_mm_frame (
  input  mdio_mm_pkg::frame_req_t req,
  output logic [31:0]             word
);
  import mdio_mm_pkg::*;

  logic        last_is_this;
  logic        wr;
  logic [4:0]  dev;
  logic [15:0] addr;
  logic [4:0]  reg5;
  logic [15:0] data;

  always_comb begin
    last_is_this = (req.kind == KIND_DIRECT) || (req.frame >= FRAME_LAST_MMD);
    wr = last_is_this ? req.is_write : 1'b1;
    if (req.kind == KIND_MMD1F) begin
      dev  = MMD_DEV_1F;
      addr = req.regnum;
    end else begin
      dev  = {1'b0, req.regnum[15:12]};
      addr = req.regnum & MMD_ADDR_MASK;
    end
    if (req.kind == KIND_DIRECT) begin
      reg5 = req.regnum[4:0];
      data = req.value;
    end else begin
      case (req.frame)
        2'd0: begin
          reg5 = REG_MMD_CTRL;
          data = {11'd0, dev};
        end
        2'd1: begin
          reg5 = REG_MMD_DATA;
          data = addr;
        end
        2'd2: begin
          reg5 = REG_MMD_CTRL;
          data = MMD_DATA_MODE | {11'd0, dev};
        end
        default: begin
          reg5 = REG_MMD_DATA;
          data = req.value;
        end
      endcase
    end
    word = {2'b01, (wr ? 2'b01 : 2'b10), req.phy, reg5,
            (wr ? 2'b10 : 2'b00), (wr ? data : 16'd0)};
  end

endmodule
`default_nettype wire

### sv/mdio_mm_core.sv
`default_nettype none
`include "mdio_management_master_unit_assert.svh"
module mdio_mm_core #(
  parameter int PREAMBLE_BITS = mdio_mm_pkg::PREAMBLE_BITS_DEF,
  parameter int PORT_COUNT    = mdio_mm_pkg::PORT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  mdio_mm_pkg::item_t   item,
  output mdio_mm_pkg::result_t res
);
  import mdio_mm_pkg::*;

  logic        active_r, active_nxt;
  logic [5:0]  bit_pos_r, bit_pos_nxt;
  logic [1:0]  frame_r, frame_nxt;
  kind_t       kind_r, kind_nxt;
  logic        is_write_r, is_write_nxt;
  logic        port_r, port_nxt;
  logic [4:0]  phy_r, phy_nxt;
  logic [15:0] reg_r, reg_nxt;
  logic [15:0] value_r, value_nxt;
  logic [31:0] tx_r, tx_nxt;
  logic [15:0] rx_r, rx_nxt;

  frame_req_t  freq;
  logic [31:0] frame_word;
  logic        is_req;
  logic        wr;
  logic [4:0]  q;

  assign freq = '{kind: kind_nxt, frame: frame_nxt, is_write: is_write_nxt,
                  phy: phy_nxt, regnum: reg_nxt, value: value_nxt};

  mdio_mm_frame u_frame (
    .req  (freq),
    .word (frame_word)
  );

  always_comb begin
    active_nxt   = active_r;
    bit_pos_nxt  = bit_pos_r;
    frame_nxt    = frame_r;
    kind_nxt     = kind_r;
    is_write_nxt = is_write_r;
    port_nxt     = port_r;
    phy_nxt      = phy_r;
    reg_nxt      = reg_r;
    value_nxt    = value_r;
    tx_nxt       = tx_r;
    rx_nxt       = rx_r;
    res          = '0;
    is_req       = (item.func == FUNC_READ) || (item.func == FUNC_WRITE);
    wr           = ((kind_r == KIND_DIRECT) || (frame_r >= FRAME_LAST_MMD)) ?
                   is_write_r : 1'b1;
    q            = 5'(bit_pos_r - 6'(PREAMBLE_BITS));

    if (is_req) begin
      if (active_r) begin
        res.status = ST_BUSY;
      end else if ({1'b0, item.port_select} >= 2'(PORT_COUNT)) begin
        res.status = ST_BAD_PORT;
      end else if (item.reg_addr > REG_MMD1F_MAX && item.reg_addr < REG_MMDDEV_MIN) begin
        res.status = ST_BAD_RANGE;
      end else begin
        port_nxt     = item.port_select;
        phy_nxt      = item.phy_addr;
        reg_nxt      = item.reg_addr;
        value_nxt    = item.write_data;
        is_write_nxt = (item.func == FUNC_WRITE);
        if (item.reg_addr < REG_DIRECT_LIMIT) begin
          kind_nxt = KIND_DIRECT;
        end else if (item.reg_addr <= REG_MMD1F_MAX) begin
          kind_nxt = KIND_MMD1F;
        end else begin
          kind_nxt = KIND_MMDDEV;
        end
        frame_nxt   = 2'd0;
        rx_nxt      = 16'd0;
        tx_nxt      = frame_word;
        bit_pos_nxt = 6'd0;
        active_nxt  = 1'b1;
      end
    end else if (item.func == FUNC_TICK && active_r) begin
      res.clock_active = 1'b1;
      if ({1'b0, bit_pos_r} < 7'(PREAMBLE_BITS)) begin
        res.mdio_out          = 1'b1;
        res.mdio_drive_enable = 1'b1;
        bit_pos_nxt           = bit_pos_r + 6'd1;
      end else begin
        if (wr || q < TAIL_READ_TA) begin
          res.mdio_drive_enable = 1'b1;
          res.mdio_out          = tx_r[TAIL_LAST - q];
        end
        if (!wr && q >= TAIL_RX_FIRST) begin
          rx_nxt = {rx_r[14:0], item.mdio_in};
        end
        if (q == TAIL_LAST) begin
          bit_pos_nxt = 6'd0;
          if ((kind_r == KIND_DIRECT) || (frame_r >= FRAME_LAST_MMD)) begin
            active_nxt   = 1'b0;
            res.done_res = 1'b1;
            if (!is_write_r) begin
              res.read_data = rx_nxt;
            end
          end else begin
            frame_nxt = frame_r + 2'd1;
            tx_nxt    = frame_word;
          end
        end else begin
          bit_pos_nxt = bit_pos_r + 6'd1;
        end
      end
    end
    res.port_sel = port_nxt;
    res.busy_res = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      bit_pos_r  <= 6'd0;
      frame_r    <= 2'd0;
      kind_r     <= KIND_DIRECT;
      is_write_r <= 1'b0;
      port_r     <= 1'b0;
      phy_r      <= 5'd0;
      reg_r      <= 16'd0;
      value_r    <= 16'd0;
      tx_r       <= 32'd0;
      rx_r       <= 16'd0;
    end else if (step) begin
      active_r   <= active_nxt;
      bit_pos_r  <= bit_pos_nxt;
      frame_r    <= frame_nxt;
      kind_r     <= kind_nxt;
      is_write_r <= is_write_nxt;
      port_r     <= port_nxt;
      phy_r      <= phy_nxt;
      reg_r      <= reg_nxt;
      value_r    <= value_nxt;
      tx_r       <= tx_nxt;
      rx_r       <= rx_nxt;
    end
  end

  `MDIO_MM_ASSERT(a_idle_pos_zero, !active_r |-> bit_pos_r == 6'd0, "idle with position set")
  `MDIO_MM_ASSERT(a_direct_frame, kind_r == KIND_DIRECT |-> frame_r == 2'd0, "frame advanced")
  `MDIO_MM_ASSERT(a_done_idle, (step && res.done_res) |=> !active_r, "active after done")
  `MDIO_MM_ASSERT(a_reject_hold, (step && res.status != ST_OK) |=> $stable(active_r), "rejected")

endmodule
`default_nettype wire

### sv/mdio_management_master_unit.sv
// Channel   Dir  Ports                          Contents
// in        in   in_tvalid/in_tready/in_tdata   request or bit-period tick, func in in_tuser
// out       out  out_tvalid/out_tready/out_tdata one result per input transaction
//
// One input transaction per cycle sustained while the output is not stalled; its result passes
// through the input register, then the result register.
// The state update and frame build for one transaction fit between those registers.
// rst_n is synchronous, active low; it clears the transaction state and both valid flags.
// A stalled output holds its result; the input register still refills while out_tready is low
// only until both registers are full, then in_tready drops.
`default_nettype none
module mdio_management_master_unit #(
  parameter int PREAMBLE_BITS = mdio_mm_pkg::PREAMBLE_BITS_DEF,
  parameter int PORT_COUNT    = mdio_mm_pkg::PORT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // port_select[0], phy_addr[5:1], reg_addr[21:6], write_data[37:22], mdio_in[38], zero[39]
  input  logic [39:0] in_tdata,
  // func[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mdio_out[0], mdio_drive_enable[1], clock_active[2], port_sel[3], busy_res[4],
  // done_res[5], read_data[21:6], status[23:22]
  output logic [23:0] out_tdata
);
  import mdio_mm_pkg::*;

  logic    in_v_r;
  item_t   item_r;
  logic    out_v_r;
  result_t out_r;
  result_t res;
  logic    step;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  mdio_mm_core #(
    .PREAMBLE_BITS (PREAMBLE_BITS),
    .PORT_COUNT    (PORT_COUNT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{func: in_tuser, port_select: in_tdata[0], phy_addr: in_tdata[5:1],
                  reg_addr: in_tdata[21:6], write_data: in_tdata[37:22],
                  mdio_in: in_tdata[38]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule
`default_nettype wire

### tb/sv/mdio_management_master_unit_tb.sv
`timescale 1ns / 100ps
module mdio_management_master_unit_tb;
  import mdio_mm_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 360;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  class mdio_frame_scoreboard;
    result_t expected_results[$];
    int unsigned error_count;
    int unsigned results_seen;
    logic busy;
    logic [5:0] bit_pos;
    logic [1:0] frame;
    kind_t access;
    logic wr_req;
    logic port;
    logic [4:0] phy;
    logic [15:0] regnum;
    logic [15:0] value;
    logic [31:0] tx_word;
    logic [15:0] rx_word;

    function new();
      busy = 1'b0;
      bit_pos = '0;
      frame = '0;
      access = KIND_DIRECT;
      wr_req = 1'b0;
      port = 1'b0;
      phy = '0;
      regnum = '0;
      value = '0;
      tx_word = '0;
      rx_word = '0;
      error_count = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [1:0] last_frame();
      return (access == KIND_DIRECT) ? 2'd0 : FRAME_LAST_MMD;
    endfunction

    function logic frame_writes();
      return (frame < last_frame()) ? 1'b1 : wr_req;
    endfunction

    function void build_frame();
      logic [15:0] dev;
      logic [15:0] addr;
      logic [15:0] data;
      logic [4:0] reg5;
      logic wr;
      if (access == KIND_MMD1F) begin
        dev = 16'(MMD_DEV_1F);
        addr = regnum;
      end else begin
        dev = {12'd0, regnum[15:12]};
        addr = regnum & MMD_ADDR_MASK;
      end
      wr = frame_writes();
      if (access == KIND_DIRECT) begin
        reg5 = regnum[4:0];
        data = value;
      end else begin
        case (frame)
          2'd0: begin
            reg5 = REG_MMD_CTRL;
            data = dev;
          end
          2'd1: begin
            reg5 = REG_MMD_DATA;
            data = addr;
          end
          2'd2: begin
            reg5 = REG_MMD_CTRL;
            data = MMD_DATA_MODE | dev;
          end
          default: begin
            reg5 = REG_MMD_DATA;
            data = value;
          end
        endcase
      end
      tx_word = {2'b01, wr ? 2'b01 : 2'b10, phy, reg5, wr ? 2'b10 : 2'b00, wr ? data : 16'h0000};
      bit_pos = '0;
    endfunction

    function result_t serialize_step(item_t it);
      result_t r;
      logic [4:0] q;
      logic wr;
      r = '0;
      if (it.func == FUNC_READ || it.func == FUNC_WRITE) begin
        if (busy) begin
          r.status = ST_BUSY;
        end else if (it.port_select >= PORT_COUNT_DEF) begin
          r.status = ST_BAD_PORT;
        end else if (it.reg_addr > REG_MMD1F_MAX && it.reg_addr < REG_MMDDEV_MIN) begin
          r.status = ST_BAD_RANGE;
        end else begin
          port = it.port_select;
          phy = it.phy_addr;
          regnum = it.reg_addr;
          value = it.write_data;
          wr_req = (it.func == FUNC_WRITE);
          if (it.reg_addr < REG_DIRECT_LIMIT) access = KIND_DIRECT;
          else if (it.reg_addr <= REG_MMD1F_MAX) access = KIND_MMD1F;
          else access = KIND_MMDDEV;
          frame = '0;
          rx_word = '0;
          build_frame();
          busy = 1'b1;
        end
      end else if (it.func == FUNC_TICK && busy) begin
        wr = frame_writes();
        r.clock_active = 1'b1;
        if (bit_pos < PREAMBLE_BITS_DEF) begin
          r.mdio_out = 1'b1;
          r.mdio_drive_enable = 1'b1;
          bit_pos = bit_pos + 6'd1;
        end else begin
          q = 5'(bit_pos - 6'(PREAMBLE_BITS_DEF));
          if (wr || q < TAIL_READ_TA) begin
            r.mdio_drive_enable = 1'b1;
            r.mdio_out = tx_word[5'd31 - q];
          end
          if (!wr && q >= TAIL_RX_FIRST) rx_word = {rx_word[14:0], it.mdio_in};
          if (q == TAIL_LAST) begin
            if (frame >= last_frame()) begin
              busy = 1'b0;
              r.done_res = 1'b1;
              if (!wr_req) r.read_data = rx_word;
              bit_pos = '0;
            end else begin
              frame = frame + 2'd1;
              build_frame();
            end
          end else begin
            bit_pos = bit_pos + 6'd1;
          end
        end
      end
      r.port_sel = port;
      r.busy_res = busy;
      return r;
    endfunction

    function void note_request(item_t it);
      expected_results.push_back(serialize_step(it));
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      error_count++;
      $display("MISMATCH %s: got %0h, want %0h (result %0d)", what, got, want, results_seen);
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("result with nothing pending", got, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.mdio_out !== want.mdio_out) report("mdio_out", got.mdio_out, want.mdio_out);
      if (got.mdio_drive_enable !== want.mdio_drive_enable)
        report("mdio_drive_enable", got.mdio_drive_enable, want.mdio_drive_enable);
      if (got.clock_active !== want.clock_active)
        report("clock_active", got.clock_active, want.clock_active);
      if (got.port_sel !== want.port_sel) report("port_sel", got.port_sel, want.port_sel);
      if (got.busy_res !== want.busy_res) report("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  mdio_frame_scoreboard sb;
  int send_idle_pct;
  int take_stall_pct;
  int work_items;
  int idle_cycles;
  int phase;

  mdio_management_master_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= (take_stall_pct == 0) || ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(item_t'({in_tuser, in_tdata[0], in_tdata[5:1], in_tdata[21:6],
                                 in_tdata[37:22], in_tdata[38]}));
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [39:0] rand_payload();
    return {1'b0, 7'($urandom_range(127)), $urandom()};
  endfunction

  function automatic logic [39:0] pack_request(logic prt, logic [4:0] pa, logic [15:0] ra,
                                               logic [15:0] wd, logic din);
    return {1'b0, din, wd, ra, pa, prt};
  endfunction

  function automatic logic [15:0] random_regnum();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 16'($urandom_range(31));
    if (roll < 80) return 16'($urandom_range(32, 16'h0EFD));
    return 16'($urandom_range(16'h1000, 16'hFFFF));
  endfunction

  task automatic push_item(input logic [1:0] fn, input logic [39:0] payload);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= payload;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic issue_request(input logic [1:0] fn, input logic prt, input logic [4:0] pa,
                               input logic [15:0] ra, input logic [15:0] wd);
    push_item(fn, pack_request(prt, pa, ra, wd, 1'($urandom_range(1))));
    work_items++;
  endtask

  task automatic clock_out(input int noise_pct);
    int roll;
    while (sb.busy) begin
      roll = $urandom_range(99);
      if (roll < noise_pct) begin
        case ($urandom_range(2))
          0: push_item(FUNC_READ, rand_payload());
          1: push_item(FUNC_WRITE, rand_payload());
          default: push_item(FUNC_SPARE, rand_payload());
        endcase
      end else begin
        push_item(FUNC_TICK, rand_payload());
      end
      work_items++;
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int roll;
    sb = new();
    send_idle_pct = 26;
    take_stall_pct = 47;
    work_items = 0;
    idle_cycles = 0;
    phase = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_item(FUNC_TICK, rand_payload());
    push_item(FUNC_SPARE, rand_payload());
    issue_request(FUNC_WRITE, 1'b0, 5'd0, 16'd0, 16'hFFFF);
    clock_out(0);
    issue_request(FUNC_READ, 1'b1, 5'd31, 16'd31, 16'h0000);
    clock_out(0);
    issue_request(FUNC_WRITE, 1'b1, 5'h15, 16'd32, 16'h0000);
    clock_out(10);
    issue_request(FUNC_READ, 1'b0, 5'h0A, REG_MMD1F_MAX, 16'hA5A5);
    clock_out(0);
    issue_request(FUNC_READ, 1'b0, 5'd3, 16'h0EFE, 16'h1234);
    issue_request(FUNC_WRITE, 1'b1, 5'd3, 16'h0FFF, 16'h4321);
    issue_request(FUNC_WRITE, 1'b1, 5'd31, REG_MMDDEV_MIN, 16'h5A5A);
    clock_out(0);
    drain_results();

    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      if (phase == 0 && work_items >= RANDOM_ITEMS / 3) begin
        phase = 1;
        send_idle_pct = 47;
        take_stall_pct = 26;
        drain_results();
      end else if (phase == 1 && work_items >= 2 * RANDOM_ITEMS / 3) begin
        phase = 2;
        send_idle_pct = 0;
        take_stall_pct = 0;
        drain_results();
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        push_item(roll < 3 ? FUNC_TICK : FUNC_SPARE, rand_payload());
        work_items++;
      end else if (roll < 10) begin
        issue_request($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 1'($urandom_range(1)),
                      5'($urandom_range(31)), 16'($urandom_range(16'h0EFE, 16'h0FFF)),
                      16'($urandom()));
      end else begin
        issue_request($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 1'($urandom_range(1)),
                      5'($urandom_range(31)), random_regnum(), 16'($urandom()));
        clock_out(5);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report("results never arrived", sb.pending(), 0);
    if (sb.error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
